[hdl/day_number_to_date_macros.svh]
// Assertion macros for the day number to date converter.
`ifndef DAY_NUMBER_TO_DATE_MACROS_SVH
`define DAY_NUMBER_TO_DATE_MACROS_SVH
`ifndef SYNTHESIS
`define DND_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("day_number_to_date assertion failed");
`define DND_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("day_number_to_date assertion failed");
`else
`define DND_ASSERT(label, prop)
`define DND_ASSERT_IMPLY(label, ante, cons)
`endif
`endif

[hdl/dnd_pkg.sv]
// Shared constants, pipeline item type and calendar helpers.
package dnd_pkg;

  localparam logic [21:0] LastDay    = 22'd3652059;
  localparam int unsigned YearSteps  = 8;
  // input register, two divide stages, the back-off stages, two month stages
  localparam int unsigned Latency    = YearSteps + 5;
  localparam int unsigned Months     = 12;
  localparam logic [23:0] Recip365   = 24'd11767033;
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam logic [8:0]  DaysInYear = 9'd365;
  localparam logic [8:0]  Century    = 9'd100;
  localparam logic [13:0] MaxYear    = 14'd9999;

  typedef struct packed {
    logic        valid;
    logic        zero;
    logic [13:0] yr;
    logic [11:0] off;
  } dnd_item_t;

  // floor(v / 100) for any 14-bit v, by reciprocal
  function automatic logic [7:0] div100(input logic [13:0] v);
    logic [26:0] prod;
    prod = 27'(v) * 27'(Recip100);
    return prod[26:19];
  endfunction

  // leap years among years 1 .. yr-1
  function automatic logic [11:0] leaps_before(input logic [13:0] yr);
    logic [13:0] p;
    logic [7:0]  c;
    p = (yr == 14'd0) ? 14'd0 : yr - 14'd1;
    c = div100(p);
    return 12'(p >> 2) - 12'(c) + 12'(c >> 2);
  endfunction

  function automatic logic is_leap(input logic [13:0] yr);
    logic [7:0] c;
    logic       hund;
    c    = div100(yr);
    hund = (15'(c) * 15'(Century)) == 15'(yr);
    return (yr[1:0] == 2'd0) && (!hund || (c[1:0] == 2'd0));
  endfunction

endpackage

[hdl/dnd_divide.sv]
// Year estimate: count / 365 by reciprocal multiply, then one correction step.
module dnd_divide (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_zero,
  input  logic [21:0]       cnt,
  output dnd_pkg::dnd_item_t out_item
);
  import dnd_pkg::*;

  logic        valid1;
  logic        zero1;
  logic [21:0] cnt1;
  logic [13:0] q1;
  logic [45:0] prod;
  logic [21:0] diff;
  logic        fix;

  assign prod = 46'(cnt) * 46'(Recip365);

  always_ff @(posedge clk) begin
    zero1 <= in_zero;
    cnt1  <= cnt;
    q1    <= prod[45:32];
    if (rst) valid1 <= 1'b0;
    else     valid1 <= in_valid;
  end

  // estimate is exact or one low; remainder stays below 730
  assign diff = cnt1 - 22'(q1) * 22'(DaysInYear);
  assign fix  = diff[9:0] >= 10'(DaysInYear);

  always_ff @(posedge clk) begin
    out_item.zero <= zero1;
    out_item.yr   <= q1 + 14'd1 + 14'(fix);
    out_item.off  <= fix ? 12'(diff[9:0] - 10'(DaysInYear)) : 12'(diff[9:0]);
    if (rst) out_item.valid <= 1'b0;
    else     out_item.valid <= valid1;
  end

endmodule

[hdl/dnd_year_step.sv]
// One year back-off step: move to the prior year while offset <= leap days before.
module dnd_year_step (
  input  logic               clk,
  input  logic               rst,
  input  dnd_pkg::dnd_item_t in_item,
  output dnd_pkg::dnd_item_t out_item
);
  import dnd_pkg::*;

  logic [11:0] leaps;
  logic        back;

  always_comb begin
    leaps = leaps_before(in_item.yr);
    back  = (in_item.yr > 14'd1) && (in_item.off <= leaps);
  end

  always_ff @(posedge clk) begin
    out_item.zero <= in_item.zero;
    out_item.yr   <= back ? in_item.yr - 14'd1 : in_item.yr;
    out_item.off  <= back ? in_item.off + 12'(DaysInYear) : in_item.off;
    if (rst) out_item.valid <= 1'b0;
    else     out_item.valid <= in_item.valid;
  end

endmodule

[hdl/dnd_month.sv]
// Leap-day removal, then parallel month search against cumulative month ends.
module dnd_month (
  input  logic               clk,
  input  logic               rst,
  input  dnd_pkg::dnd_item_t in_item,
  output logic               done,
  output logic [13:0]        year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_of_month
);
  import dnd_pkg::*;

  localparam logic [8:0] MonthEnd [Months] = '{
    9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };
  localparam logic [8:0] MonthStart [Months] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  logic        valid_a;
  logic        zero_a;
  logic        leap_a;
  logic [13:0] yr_a;
  logic [11:0] off_a;
  logic [3:0]  mo;
  logic [4:0]  dy;
  logic [9:0]  ends   [Months];
  logic [9:0]  starts [Months];

  always_ff @(posedge clk) begin
    zero_a <= in_item.zero;
    yr_a   <= in_item.yr;
    off_a  <= in_item.off - leaps_before(in_item.yr);
    leap_a <= is_leap(in_item.yr);
    if (rst) valid_a <= 1'b0;
    else     valid_a <= in_item.valid;
  end

  // scan from December down so the earliest matching month wins;
  // no match falls back to 31 December
  always_comb begin
    mo = 4'd12;
    dy = 5'd31;
    for (int k = Months - 1; k >= 0; k--) begin
      ends[k]   = 10'(MonthEnd[k]) + 10'(leap_a && (k >= 1));
      starts[k] = 10'(MonthStart[k]) + 10'(leap_a && (k >= 2));
      if (off_a <= 12'(ends[k])) begin
        mo = 4'(k + 1);
        dy = 5'(off_a - 12'(starts[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    year_out     <= zero_a ? 14'd1 : yr_a;
    month_out    <= zero_a ? 4'd1  : mo;
    day_of_month <= zero_a ? 5'd1  : dy;
    if (rst) done <= 1'b0;
    else     done <= valid_a;
  end

endmodule

[hdl/day_number_to_date.sv]
// Every start transfer gives a done strobe, in the order of the starts.
// Throughput: one day count per cycle; busy is always low.
// The pipeline is set by the reciprocal divide, eight year back-off stages
// and the month search; results leave on a one-cycle strobe, no stall.
// Reset (synchronous, active high) clears all valid bits; items in flight
// are dropped.
module day_number_to_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [21:0] day_count,
  output logic        done,
  output logic [13:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_of_month
);
  import dnd_pkg::*;

  `include "day_number_to_date_macros.svh"

  logic        valid0;
  logic        zero0;
  logic [21:0] cnt0;
  dnd_item_t   chain [YearSteps + 1];

  assign busy = 1'b0;

  // saturate to the last day of year 9999
  always_ff @(posedge clk) begin
    cnt0  <= (day_count > LastDay) ? LastDay : day_count;
    zero0 <= day_count == 22'd0;
    if (rst) valid0 <= 1'b0;
    else     valid0 <= start && !busy;
  end

  dnd_divide u_divide (
    .clk      (clk),
    .rst      (rst),
    .in_valid (valid0),
    .in_zero  (zero0),
    .cnt      (cnt0),
    .out_item (chain[0])
  );

  for (genvar g = 0; g < YearSteps; g++) begin : g_step
    dnd_year_step u_step (
      .clk      (clk),
      .rst      (rst),
      .in_item  (chain[g]),
      .out_item (chain[g + 1])
    );
  end

  dnd_month u_month (
    .clk          (clk),
    .rst          (rst),
    .in_item      (chain[YearSteps]),
    .done         (done),
    .year_out     (year_out),
    .month_out    (month_out),
    .day_of_month (day_of_month)
  );

  `DND_ASSERT_IMPLY(a_latency, start && !busy, ##Latency done)
  `DND_ASSERT_IMPLY(a_no_spurious, done, $past(start && !busy, Latency))
  `DND_ASSERT_IMPLY(a_month_range, done, (month_out >= 4'd1) && (month_out <= 4'd12))
  `DND_ASSERT_IMPLY(a_day_range, done, (day_of_month >= 5'd1) && (day_of_month <= 5'd31))
  `DND_ASSERT(a_year_range, done |-> (year_out >= 14'd1) && (year_out <= MaxYear))

endmodule
